// ----- rtl/core/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the packed array unpacker.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int WORD_BITS   = 64;
    localparam int POS_W       = 7;
    localparam int ENTRY_W     = 32;
    localparam int BITCNT_W    = 5;
    localparam int INDEX_W     = 12;
    localparam int BPE_W       = 6;
    localparam int CNT_W       = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int OUT_TDATA_W = 48;

    localparam logic CFG_ENTRY_WIDTH = 1'b0;
    localparam logic CFG_ENTRY_COUNT = 1'b1;

    localparam logic [BPE_W-1:0] BPE_RESET   = 6'd4;
    localparam logic [CNT_W-1:0] COUNT_RESET = 13'd4096;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    typedef struct packed {
        logic entry_done;
        logic next_fits;
    } deser_stat_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               run_last;
        logic               complete;
    } entry_tag_t;

endpackage

// ----- rtl/core/ple_deser.sv -----
// ----------------------------------------------------------------------------
// ple_deser
// Bit-serial deserialiser: shifts the word out one bit per cycle while step
// is high and assembles entries of the configured width.
// ----------------------------------------------------------------------------
module ple_deser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [ple_pkg::WORD_BITS-1:0] word,
    input  logic                          step,
    input  logic [ple_pkg::BPE_W-1:0]     width,
    output ple_pkg::deser_stat_t          stat,
    output logic [ple_pkg::ENTRY_W-1:0]   entry
);
    import ple_pkg::*;

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic [BITCNT_W-1:0]  bit_cnt_reg;
    logic [BITCNT_W-1:0]  bit_cnt_next;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [ENTRY_W-1:0]   entry_reg;
    logic [ENTRY_W-1:0]   entry_next;
    logic [ENTRY_W-1:0]   entry_base;
    logic [POS_W:0]       end_pos;

    assign stat.entry_done = ({1'b0, bit_cnt_reg} == (width - BPE_W'(1)));
    assign end_pos         = {1'b0, pos_reg} + (POS_W+1)'(1) + (POS_W+1)'(width);
    assign stat.next_fits  = (end_pos <= (POS_W+1)'(WORD_BITS));

    assign entry_base = (bit_cnt_reg == '0) ? '0 : entry_reg;
    assign entry_next = entry_base | (ENTRY_W'(word_reg[0]) << bit_cnt_reg);
    assign entry      = entry_next;

    always_comb
    begin
        word_next    = word_reg;
        bit_cnt_next = bit_cnt_reg;
        pos_next     = pos_reg;
        if (load)
        begin
            word_next    = word;
            bit_cnt_next = '0;
            pos_next     = '0;
        end
        else if (step)
        begin
            word_next    = {1'b0, word_reg[WORD_BITS-1:1]};
            pos_next     = pos_reg + POS_W'(1);
            bit_cnt_next = stat.entry_done ? '0 : bit_cnt_reg + BITCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            bit_cnt_reg <= bit_cnt_next;
            pos_reg     <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (step)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ----- rtl/core/ple_outreg.sv -----
// ----------------------------------------------------------------------------
// ple_outreg
// Output register of the result stream.
// ----------------------------------------------------------------------------
module ple_outreg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic [ple_pkg::ENTRY_W-1:0]     value,
    input  ple_pkg::entry_tag_t             tag,
    output logic                            busy,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ple_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    output logic                            m_axis_tuser
);
    import ple_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [ENTRY_W-1:0] value_reg;
    entry_tag_t         tag_reg;

    assign busy       = valid_reg && !m_axis_tready;
    assign valid_next = load ? 1'b1 : (m_axis_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value;
            tag_reg   <= tag;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W-ENTRY_W-INDEX_W)'(0), tag_reg.index, value_reg};
    assign m_axis_tlast  = tag_reg.run_last;
    assign m_axis_tuser  = tag_reg.complete;

endmodule

// ----- rtl/core/packed_long_array_unpacker_top.sv -----
// ----------------------------------------------------------------------------
// packed_long_array_unpacker_top
// Splits 64-bit packed words into fixed-width entries, bit-serially.
// ----------------------------------------------------------------------------
// Each accepted word is loaded into the deserialiser, which shifts out one bit
// per cycle unless a finished entry waits on a stalled output; every w bits
// form an entry (w = effective entry width) for the output register. No new
// word is accepted until the current one is done; a word after the array is full is dropped.
// Reset: asynchronous, active low; clears the count, the full flag, the
// output valid and restores entry width = 4, entry count = 4096.
module packed_long_array_unpacker_top #(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [ple_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // packed_word[63:0]
    input  logic [ple_pkg::WORD_BITS-1:0]   s_axis_tdata,
    // last_word
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // entry_value[31:0], entry_index[43:32], zero [47:44]
    output logic [ple_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // run_last
    output logic                            m_axis_tlast,
    // array_complete
    output logic                            m_axis_tuser
);
    import ple_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (CW > CNT_W) ? CW : CNT_W;

    state_t             state_reg;
    state_t             state_next;
    logic [BPE_W-1:0]   bpe_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CW-1:0]      emitted_reg;
    logic [CW-1:0]      emitted_next;
    logic               full_reg;
    logic               full_next;
    logic               last_reg;

    logic [BPE_W-1:0]   width_eff;
    logic [CNT_W-1:0]   count_nz;
    logic [EW-1:0]      count_eff;
    logic [EW-1:0]      emitted_ext;
    logic [CW-1:0]      emitted_inc;
    logic [EW-1:0]      emitted_inc_ext;
    logic               start_full;
    logic               accept;
    logic               deser_load;
    logic               step;
    logic               emit;
    logic               hit;
    logic               out_busy;
    deser_stat_t        stat;
    logic [ENTRY_W-1:0] entry;
    entry_tag_t         tag;

    always_comb
    begin
        width_eff = bpe_reg;
        if (bpe_reg == '0)
        begin
            width_eff = BPE_W'(1);
        end
        else if (bpe_reg > BPE_W'(ENTRY_W))
        begin
            width_eff = BPE_W'(ENTRY_W);
        end
    end

    assign count_nz  = (count_reg == '0) ? CNT_W'(1) : count_reg;
    assign count_eff = (EW'(count_nz) > EW'(MAX_ENTRIES)) ? EW'(MAX_ENTRIES) : EW'(count_nz);

    assign emitted_ext     = EW'(emitted_reg);
    assign emitted_inc     = emitted_reg + CW'(1);
    assign emitted_inc_ext = EW'(emitted_inc);
    assign hit             = (emitted_inc_ext >= count_eff);
    assign start_full      = full_reg || (emitted_ext >= count_eff);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign deser_load    = accept && !start_full;
    assign step          = (state_reg == ST_RUN) && !(stat.entry_done && out_busy);
    assign emit          = step && stat.entry_done;

    assign tag.index    = emitted_ext[INDEX_W-1:0];
    assign tag.run_last = hit || !stat.next_fits;
    assign tag.complete = (emitted_inc_ext == count_eff);

    always_comb
    begin
        state_next   = state_reg;
        emitted_next = emitted_reg;
        full_next    = full_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!start_full)
                    begin
                        state_next = ST_RUN;
                    end
                    else if (s_axis_tlast)
                    begin
                        emitted_next = '0;
                        full_next    = 1'b0;
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                if (emit)
                begin
                    emitted_next = emitted_inc;
                    if (tag.run_last)
                    begin
                        state_next = ST_IDLE;
                        if (last_reg)
                        begin
                            emitted_next = '0;
                            full_next    = 1'b0;
                        end
                        else
                        begin
                            full_next = hit;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            emitted_reg <= '0;
            full_reg    <= 1'b0;
            bpe_reg     <= BPE_RESET;
            count_reg   <= COUNT_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            emitted_reg <= emitted_next;
            full_reg    <= full_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ENTRY_WIDTH: bpe_reg   <= cfg_data[BPE_W-1:0];
                    CFG_ENTRY_COUNT: count_reg <= cfg_data[CNT_W-1:0];
                    default:         count_reg <= count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= s_axis_tlast;
        end
    end

    ple_deser u_deser (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (deser_load),
        .word  (s_axis_tdata),
        .step  (step),
        .width (width_eff),
        .stat  (stat),
        .entry (entry)
    );

    ple_outreg u_outreg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (emit),
        .value         (entry),
        .tag           (tag),
        .busy          (out_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- rtl/core/ple_checker.sv -----
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks of the packed array unpacker, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ple_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast,
    input logic                            m_axis_tuser
);
    import ple_pkg::*;

    logic               out_acc;
    logic               mid_word_reg;
    logic [INDEX_W-1:0] idx_reg;

    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_word_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else if (out_acc)
        begin
            mid_word_reg <= !m_axis_tlast;
            idx_reg      <= m_axis_tdata[ENTRY_W +: INDEX_W];
        end
    end

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_complete_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("array complete without run end");

    a_index_advance: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && mid_word_reg |->
            m_axis_tdata[ENTRY_W +: INDEX_W] == idx_reg + INDEX_W'(1))
        else $error("entry index did not advance by one");

    a_no_input_mid_word: assert property (@(posedge clk) disable iff (!rst_n)
        mid_word_reg && !m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a word is in progress");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:ENTRY_W+INDEX_W] == '0)
        else $error("padding bits not zero");

endmodule

bind packed_long_array_unpacker_top ple_checker u_ple_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
